>>> hdl/keyed_min_score_table_assert.svh
// assertion macros used by the keyed min score table datapath
`ifndef KEYED_MIN_SCORE_TABLE_ASSERT_SVH
`define KEYED_MIN_SCORE_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KMST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define KMST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/kmst_pkg.sv
// shared types and constants for the keyed min score table
package kmst_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int SCORE_LIMIT_DEFAULT = 25600;   // 100.0 in 8.8 fixed point

   localparam int OP_W    = 3;
   localparam int KEY_W   = 16;
   localparam int SCORE_W = 16;
   localparam int STAT_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT    = 3'd0,
      OP_FIND_MIN  = 3'd1,
      OP_FIND_NEXT = 3'd2,
      OP_DELETE    = 3'd3,
      OP_CHANGE    = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the request
      logic start;    // set up a sweep
      logic issue;    // read one slot and step the index
      logic finish;   // apply side effects and load the response
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic no_scan;
      logic scan_last;
      logic rsp_free;
   } dp_stat_type;

endpackage

>>> hdl/kmst_ctrl.sv
// sequencer for the keyed min score table sweeps
module kmst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output kmst_pkg::ctl_cmd_type cmd,
   input  kmst_pkg::dp_stat_type stat
);
   import kmst_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.no_scan) begin
               state_in = ST_FINISH;
            end else begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read word is consumed here
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/kmst_dpath.sv
// slot memory, sweep datapath and response register
`include "keyed_min_score_table_assert.svh"

module kmst_dpath #(
   parameter int DEPTH       = kmst_pkg::DEPTH_DEFAULT,
   parameter int SCORE_LIMIT = kmst_pkg::SCORE_LIMIT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kmst_pkg::ctl_cmd_type         cmd,
   output kmst_pkg::dp_stat_type         stat,
   input  logic [kmst_pkg::OP_W-1:0]     req_op,
   input  logic [kmst_pkg::KEY_W-1:0]    req_key,
   input  logic [kmst_pkg::SCORE_W-1:0]  req_score,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [kmst_pkg::KEY_W-1:0]    rsp_key,
   output logic [kmst_pkg::SCORE_W-1:0]  rsp_score,
   output logic [kmst_pkg::STAT_W-1:0]   rsp_status
);
   import kmst_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type slot_mem [DEPTH];

   logic [OP_W-1:0]    op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [SCORE_W-1:0] score_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   entry_type          rd_data_ff;

   logic [SCORE_W-1:0] best_ff, best_in;
   logic [KEY_W-1:0]   best_key_ff, best_key_in;
   logic               found_ff, found_in;

   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   status_type         rsp_status_ff;

   logic               op_known;
   logic               is_insert;
   logic               is_empty;
   logic               is_full;
   logic               op_go;
   status_type         status_code;
   logic               key_hit;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   // ---- decode of the captured request ----
   always_comb begin
      op_known  = (op_ff <= OP_CHANGE);
      is_insert = (op_ff == OP_INSERT);
      is_empty  = (count_ff == '0);
      is_full   = (count_ff == CNT_W'(DEPTH));
      key_hit   = (rd_data_ff.key == key_ff);
      priority if (!op_known) begin
         status_code = STAT_OK;
      end else if (!is_insert && is_empty) begin
         status_code = STAT_EMPTY;
      end else if (is_insert && is_full) begin
         status_code = STAT_FULL;
      end else begin
         status_code = STAT_OK;
      end
      op_go = op_known && (status_code == STAT_OK);

      stat.no_scan   = !op_known || is_empty || (is_insert && is_full);
      stat.scan_last = is_insert ? (idx_ff == '0)
                                 : (CNT_W'(idx_ff) == count_ff - CNT_W'(1));
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // ---- slot memory write port ----
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data_ff;
      priority if (cmd.finish && op_go && is_insert) begin
         wr_en         = 1'b1;
         wr_addr       = '0;
         wr_data.key   = key_ff;
         wr_data.score = score_ff;
      end else if (rd_vld_ff) begin
         unique case (op_ff)
            OP_INSERT: begin
               // shift one slot toward the old end
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff + IDX_W'(1);
            end
            OP_DELETE: begin
               // compact survivors toward slot zero
               wr_en   = !key_hit;
               wr_addr = wr_ptr_ff[IDX_W-1:0];
            end
            OP_CHANGE: begin
               wr_en         = key_hit;
               wr_addr       = rd_idx_ff;
               wr_data.score = score_ff;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
         rd_data_ff <= slot_mem[idx_ff];
      end
   end

   // ---- sweep bookkeeping and search ----
   always_comb begin
      idx_in      = idx_ff;
      wr_ptr_in   = wr_ptr_ff;
      best_in     = best_ff;
      best_key_in = best_key_ff;
      found_in    = found_ff;
      count_in    = count_ff;

      if (cmd.start) begin
         idx_in    = is_insert ? IDX_W'(count_ff - CNT_W'(1)) : '0;
         wr_ptr_in = '0;
      end else if (cmd.issue) begin
         idx_in = is_insert ? idx_ff - IDX_W'(1) : idx_ff + IDX_W'(1);
      end

      if (cmd.load) begin
         best_in     = SCORE_W'(SCORE_LIMIT);
         best_key_in = '0;
         found_in    = 1'b0;
      end else if (rd_vld_ff) begin
         if (op_ff == OP_FIND_MIN && rd_data_ff.score < best_ff) begin
            best_in     = rd_data_ff.score;
            best_key_in = rd_data_ff.key;
            found_in    = 1'b1;
         end
         if (op_ff == OP_FIND_NEXT && rd_data_ff.score <= best_ff &&
             rd_data_ff.score >= score_ff && !key_hit) begin
            best_in     = rd_data_ff.score;
            best_key_in = rd_data_ff.key;
            found_in    = 1'b1;
         end
         if (op_ff == OP_DELETE && !key_hit) begin
            wr_ptr_in = wr_ptr_ff + CNT_W'(1);
         end
      end

      if (cmd.finish && op_go) begin
         if (is_insert) begin
            count_in = count_ff + CNT_W'(1);
         end else if (op_ff == OP_DELETE) begin
            count_in = wr_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_vld_ff <= cmd.issue;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      wr_ptr_ff   <= wr_ptr_in;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
      found_ff    <= found_in;
      if (cmd.issue) begin
         rd_idx_ff <= idx_ff;
      end
      if (cmd.load) begin
         op_ff    <= req_op;
         key_ff   <= req_key;
         score_ff <= req_score;
      end
      if (cmd.finish) begin
         rsp_found_ff  <= found_ff;
         rsp_key_ff    <= found_ff ? best_key_ff : '0;
         rsp_score_ff  <= found_ff ? best_ff : '0;
         rsp_status_ff <= status_code;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_key    = rsp_key_ff;
   assign rsp_score  = rsp_score_ff;
   assign rsp_status = rsp_status_ff;

   `KMST_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH),
      "entry count above depth")
   `KMST_ASSERT_NOW(a_compact_order, rd_vld_ff && op_ff == OP_DELETE,
      wr_ptr_ff <= CNT_W'(rd_idx_ff), "compaction write overtook read")
   `KMST_ASSERT_NEXT(a_insert_count, cmd.finish && op_go && is_insert,
      count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow the table")
   `KMST_ASSERT_NOW(a_rsp_no_overwrite, cmd.finish, !rsp_valid_ff || rsp_ready,
      "pending response overwritten")

endmodule

>>> hdl/keyed_min_score_table.sv
// top level of the keyed min score table
//
// Holds up to DEPTH entries of (key, score), newest first, in a slot memory
// with one write port and one registered read port. Every request gives exactly one
// response. Insert, find-min, find-next, delete and change each sweep the
// occupied slots one per cycle through the memory read port; a new request
// is taken only after the previous one has finished its sweep. Requests
// that need no sweep (empty table, full table on insert, unknown op code,
// insert into an empty table) go from the check straight to the response.
// A finished response sits in an output register, so the next request
// transfer can happen while the previous response still waits.
// Scores are unsigned 8.8 fixed point; SCORE_LIMIT is the find limit.
module keyed_min_score_table #(
   parameter int DEPTH       = kmst_pkg::DEPTH_DEFAULT,
   parameter int SCORE_LIMIT = kmst_pkg::SCORE_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // key [15:0], score [31:16]
   input  logic [2:0]  req_tuser,    // op [2:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // key_out [15:0], score_out [31:16]
   output logic [2:0]  rsp_tuser     // found [0], status [2:1]
);
   import kmst_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   logic               rsp_found;
   logic [KEY_W-1:0]   rsp_key;
   logic [SCORE_W-1:0] rsp_score;
   logic [STAT_W-1:0]  rsp_status;

   // sequencer: accepts a request, runs the sweep, hands off the response
   kmst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // slot memory, compare logic and response register
   kmst_dpath #(
      .DEPTH       (DEPTH),
      .SCORE_LIMIT (SCORE_LIMIT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser[OP_W-1:0]),
      .req_key    (req_tdata[KEY_W-1:0]),
      .req_score  (req_tdata[KEY_W+SCORE_W-1:KEY_W]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_found  (rsp_found),
      .rsp_key    (rsp_key),
      .rsp_score  (rsp_score),
      .rsp_status (rsp_status)
   );

   // pack the response fields, lowest first
   assign rsp_tdata = {rsp_score, rsp_key};
   assign rsp_tuser = {rsp_status, rsp_found};

endmodule
